[rtl/btsb_pkg.sv]
// Shared types and constants for the byte taint shadow bitmap.
`timescale 1ns / 1ps
package btsb_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CountW = 7;
  localparam int unsigned OfsW   = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StatW  = 2;

  localparam int unsigned DefWindowAddrBits = 20;
  localparam int unsigned DefMaxRange       = 64;

  localparam logic [OpW-1:0] OP_SET   = 3'd0;
  localparam logic [OpW-1:0] OP_CLEAR = 3'd1;
  localparam logic [OpW-1:0] OP_COPY  = 3'd2;
  localparam logic [OpW-1:0] OP_CHECK = 3'd3;
  localparam logic [OpW-1:0] OP_READ  = 3'd4;

  localparam logic [ByteW-1:0] SHADOW_TAINTED = 8'hff;
  localparam logic [ByteW-1:0] SHADOW_CLEAN   = 8'h00;

  typedef enum logic [StatW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_TAINT  = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_SHADOW = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RANGE,
    ST_WRITE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

endpackage

[rtl/btsb_ram.sv]
// Single-bit shadow store: one write port, one registered read port.
`timescale 1ns / 1ps
module btsb_ram #(
  parameter int unsigned AddrBits = 20
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic                wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic                rdata_o
);

  logic mem_q [2**AddrBits];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/byte_taint_shadow_bitmap.sv]
// Top level of the byte taint shadow bitmap: command sequencer and result register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one range command per item:
//   opcode, target and source linear addresses, byte count. Output channel
//   (out_valid_o / out_ready_i) returns result items; every command gives one
//   item with last_result set, except a non-empty in-range read shadow, which
//   gives one item per byte and sets last_result on the final one. cfg_we_i
//   writes window_base from cfg_wdata_i; the user keeps this to idle, unenforced.
// Operation:
//   One command at a time; the shadow store is one bit wide with a registered
//   read, so set/clear writes each byte position in ST_WRITE, while copy,
//   check and read shadow take ST_READ, then ST_EVAL (read, then use) for each
//   byte position.
// Reset:
//   Asynchronous, active low. Afterwards the store is cleared by a pass over all
//   2**WINDOW_ADDR_BITS bits, one bit a cycle, with in_ready_o low.
// Stalls:
//   A result waits in the output register; the sequencer holds until it is
//   taken before emitting the next one. in_ready_o returns once the last result
//   has been loaded into the output register.
`timescale 1ns / 1ps
module byte_taint_shadow_bitmap
  import btsb_pkg::*;
#(
  parameter int unsigned WINDOW_ADDR_BITS = DefWindowAddrBits,
  parameter int unsigned MAX_RANGE        = DefMaxRange
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [AddrW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OpW-1:0]    opcode_i,
  input  logic [AddrW-1:0]  target_address_i,
  input  logic [AddrW-1:0]  source_address_i,
  input  logic [CountW-1:0] byte_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [StatW-1:0]  status_o,
  output logic [OfsW-1:0]   first_tainted_offset_o,
  output logic [ByteW-1:0]  shadow_byte_o,
  output logic              last_result_o
);

  localparam int unsigned W = WINDOW_ADDR_BITS;
  localparam logic [W:0] WinSize = (W+1)'(1) << W;
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_RANGE);

  state_e state_q, state_d;

  logic [AddrW-1:0]  base_q;
  logic [OpW-1:0]    op_q;
  logic [AddrW-1:0]  tgt_q, src_q;
  logic [CountW-1:0] cnt_q;
  logic [W-1:0]      t_off_q, t_off_d, s_off_q, s_off_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [W-1:0]      clr_q, clr_d;
  status_e           res_status_q, res_status_d;
  logic [OfsW-1:0]   res_ofs_q, res_ofs_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [OfsW-1:0]   out_ofs_q, out_ofs_d;
  logic [ByteW-1:0]  out_sb_q, out_sb_d;
  logic              out_last_q, out_last_d;

  logic              mem_we, mem_wdata, mem_re, mem_rdata;
  logic [W-1:0]      mem_waddr, mem_raddr;
  logic [W-1:0]      t_pos, s_pos;
  logic [AddrW-1:0]  t_rel, s_rel;
  logic [W:0]        t_end, s_end;
  logic              t_ok, s_ok, cnt_ok, last_idx, slot_free, out_load, in_acc;

  btsb_ram #(
    .AddrBits(W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign t_rel  = tgt_q - base_q;
  assign s_rel  = src_q - base_q;
  assign t_end  = {1'b0, t_rel[W-1:0]} + (W+1)'(cnt_q);
  assign s_end  = {1'b0, s_rel[W-1:0]} + (W+1)'(cnt_q);
  assign cnt_ok = (cnt_q <= MaxCount);
  assign t_ok   = (t_rel[AddrW-1:W] == '0) && (t_end <= WinSize);
  assign s_ok   = (s_rel[AddrW-1:W] == '0) && (s_end <= WinSize);

  assign t_pos    = t_off_q + W'(idx_q);
  assign s_pos    = s_off_q + W'(idx_q);
  assign last_idx = ((idx_q + CountW'(1)) == cnt_q);

  always_comb begin
    state_d      = state_q;
    t_off_d      = t_off_q;
    s_off_d      = s_off_q;
    idx_d        = idx_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_ofs_d    = res_ofs_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_ofs_d    = out_ofs_q;
    out_sb_d     = out_sb_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = t_pos;
    mem_wdata    = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = t_pos;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        idx_d = '0;
        if (in_acc) begin
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        t_off_d      = t_rel[W-1:0];
        s_off_d      = s_rel[W-1:0];
        res_status_d = STATUS_OK;
        res_ofs_d    = '0;
        state_d      = ST_DONE;
        if (op_q > OP_READ) begin
          res_status_d = STATUS_OK;
        end else if (!cnt_ok || !t_ok || ((op_q == OP_COPY) && !s_ok)) begin
          res_status_d = STATUS_RANGE;
        end else if (cnt_q == '0) begin
          res_status_d = STATUS_OK;
        end else if ((op_q == OP_SET) || (op_q == OP_CLEAR)) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = (op_q == OP_SET);
        idx_d     = idx_q + CountW'(1);
        if (last_idx) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = (op_q == OP_COPY) ? s_pos : t_pos;
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        case (op_q)
          OP_COPY: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            idx_d     = idx_q + CountW'(1);
            state_d   = last_idx ? ST_DONE : ST_READ;
          end
          OP_CHECK: begin
            idx_d = idx_q + CountW'(1);
            if (mem_rdata) begin
              res_status_d = STATUS_TAINT;
              res_ofs_d    = idx_q[OfsW-1:0];
              state_d      = ST_DONE;
            end else begin
              state_d = last_idx ? ST_DONE : ST_READ;
            end
          end
          default: begin
            if (slot_free) begin
              out_load     = 1'b1;
              out_status_d = STATUS_SHADOW;
              out_ofs_d    = '0;
              out_sb_d     = mem_rdata ? SHADOW_TAINTED : SHADOW_CLEAN;
              out_last_d   = last_idx;
              idx_d        = idx_q + CountW'(1);
              state_d      = last_idx ? ST_IDLE : ST_READ;
            end
          end
        endcase
      end
      ST_DONE: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_status_d = res_status_q;
          out_ofs_d    = res_ofs_q;
          out_sb_d     = SHADOW_CLEAN;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      tgt_q <= target_address_i;
      src_q <= source_address_i;
      cnt_q <= byte_count_i;
    end
    t_off_q      <= t_off_d;
    s_off_q      <= s_off_d;
    res_status_q <= res_status_d;
    res_ofs_q    <= res_ofs_d;
    out_status_q <= out_status_d;
    out_ofs_q    <= out_ofs_d;
    out_sb_q     <= out_sb_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o            = out_valid_q;
  assign status_o               = out_status_q;
  assign first_tainted_offset_o = out_ofs_q;
  assign shadow_byte_o          = out_sb_q;
  assign last_result_o          = out_last_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("shadow store read and written in the same cycle");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("item accepted during clearing pass");

  a_taint_ofs_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (out_status_d == STATUS_TAINT)) |-> ({1'b0, out_ofs_d} < cnt_q))
    else $error("tainted offset beyond byte count");

  a_sb_only_shadow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_SHADOW)) |-> (shadow_byte_o == SHADOW_CLEAN))
    else $error("shadow byte set on a non-shadow result");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_SHADOW)) |-> last_result_o)
    else $error("single result item without last flag");

endmodule
